@@ rtl/grr_pkg.sv @@
// shared constants and controller/datapath interface types for the group reverse reorderer
`default_nettype none

package grr_pkg;

    // data and register widths
    localparam int VALUE_W = 32;
    localparam int RLEN_W  = 7;
    localparam int PLEN_W  = 16;
    localparam int CNT_W   = 7;

    // default group store depth
    localparam int MAX_GROUP_DEF = 64;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_LEN    = 1'd1;

    // commands from controller to datapath
    typedef struct packed {
        logic             wr_en;        // store the input value at address count
        logic             bypass_load;  // load the input value into the output register
        logic             bypass_blast; // burst_last for the bypassed value
        logic             bypass_slast; // stream last for the bypassed value
        logic             drain_start;  // read back count stored values, newest first
        logic             drain_slast;  // the drained burst ends the stream
        logic [CNT_W-1:0] count;        // write address or drain length
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free; // output register can take an item this cycle
        logic busy;     // drain reads or read data still pending
    } status_t;

endpackage

`default_nettype wire

@@ rtl/grr_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module grr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/grr_dp.sv @@
// datapath: group store, drain read pipeline and output register
`default_nettype none

module grr_dp #(
    parameter int MAX_GROUP = grr_pkg::MAX_GROUP_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire grr_pkg::cmd_t               cmd,
    output grr_pkg::status_t                 sts,
    input  wire logic [grr_pkg::VALUE_W-1:0] in_value,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [grr_pkg::VALUE_W-1:0] m_tdata,
    output logic                             m_tlast,
    output logic                             m_tuser
);

    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

    logic                        out_valid_reg, out_valid_next;
    logic [grr_pkg::VALUE_W-1:0] out_value_reg, out_value_next;
    logic                        out_blast_reg, out_blast_next;
    logic                        out_slast_reg, out_slast_next;
    logic [grr_pkg::CNT_W-1:0]   rem_reg, rem_next;
    logic [AW-1:0]               rd_addr_reg, rd_addr_next;
    logic                        rv_reg, rv_next;
    logic                        rv_first_reg, rv_first_next;
    logic                        slast_hold_reg, slast_hold_next;
    logic [grr_pkg::CNT_W-1:0]   start_addr;
    logic                        out_free;
    logic                        move;
    logic                        issue;
    logic [grr_pkg::VALUE_W-1:0] ram_rdata;

    grr_ram #(
        .WIDTH(grr_pkg::VALUE_W),
        .DEPTH(MAX_GROUP)
    ) u_store (
        .aclk (aclk),
        .we   (cmd.wr_en),
        .waddr(cmd.count[AW-1:0]),
        .wdata(in_value),
        .re   (issue),
        .raddr(rd_addr_reg),
        .rdata(ram_rdata)
    );

    // handshake status
    assign out_free = !out_valid_reg || m_tready;
    assign move     = rv_reg && out_free;
    assign issue    = (rem_reg != '0) && (!rv_reg || move);
    assign sts.out_free = out_free;
    assign sts.busy     = (rem_reg != '0) || rv_reg;
    assign start_addr   = cmd.count - grr_pkg::CNT_W'(1);

    // drain sequencing and output register
    always_comb begin
        rem_next        = rem_reg;
        rd_addr_next    = rd_addr_reg;
        rv_next         = rv_reg;
        rv_first_next   = rv_first_reg;
        slast_hold_next = slast_hold_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_blast_next  = out_blast_reg;
        out_slast_next  = out_slast_reg;

        if (cmd.drain_start) begin
            rem_next        = cmd.count;
            rd_addr_next    = start_addr[AW-1:0];
            slast_hold_next = cmd.drain_slast;
        end else if (issue) begin
            rem_next      = rem_reg - grr_pkg::CNT_W'(1);
            rd_addr_next  = rd_addr_reg - AW'(1);
            rv_next       = 1'b1;
            // the read of address zero closes the burst
            rv_first_next = (rem_reg == grr_pkg::CNT_W'(1));
        end else if (move) begin
            rv_next = 1'b0;
        end

        if (cmd.bypass_load) begin
            out_valid_next = 1'b1;
            out_value_next = in_value;
            out_blast_next = cmd.bypass_blast;
            out_slast_next = cmd.bypass_slast;
        end else if (move) begin
            out_valid_next = 1'b1;
            out_value_next = ram_rdata;
            out_blast_next = rv_first_reg;
            out_slast_next = rv_first_reg && slast_hold_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
            rv_reg        <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
            rv_reg        <= rv_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rd_addr_reg    <= rd_addr_next;
        rv_first_reg   <= rv_first_next;
        slast_hold_reg <= slast_hold_next;
        out_value_reg  <= out_value_next;
        out_blast_reg  <= out_blast_next;
        out_slast_reg  <= out_slast_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tlast  = out_slast_reg;
    assign m_tuser  = out_blast_reg;

endmodule

`default_nettype wire

@@ rtl/grr_ctrl.sv @@
// controller: phase state machine, fill and pass counters, configuration registers
`default_nettype none

module grr_ctrl #(
    parameter int MAX_GROUP = grr_pkg::MAX_GROUP_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [grr_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [grr_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic                           s_tlast,
    input  wire grr_pkg::status_t               sts,
    output grr_pkg::cmd_t                       cmd
);

    localparam int FW = $clog2(MAX_GROUP + 1);

    typedef enum logic {
        ST_ACCEPT,
        ST_DRAIN
    } state_t;

    state_t                     state_reg, state_next;
    logic [FW-1:0]              fill_reg, fill_next;
    logic                       phase_reg, phase_next;
    logic [grr_pkg::PLEN_W-1:0] pass_cnt_reg, pass_cnt_next;
    logic [grr_pkg::RLEN_W-1:0] rlen_reg, rlen_next;
    logic [grr_pkg::PLEN_W-1:0] plen_reg, plen_next;
    logic [grr_pkg::RLEN_W-1:0] limit;
    logic [FW-1:0]              fill_inc;
    logic [grr_pkg::PLEN_W-1:0] pass_inc;
    logic                       accept;
    logic                       flush;
    logic                       empty;

    // effective group length, clamped to 1..MAX_GROUP
    always_comb begin
        if (rlen_reg == '0) begin
            limit = grr_pkg::RLEN_W'(1);
        end else if (rlen_reg > grr_pkg::RLEN_W'(MAX_GROUP)) begin
            limit = grr_pkg::RLEN_W'(MAX_GROUP);
        end else begin
            limit = rlen_reg;
        end
    end

    assign s_tready = (state_reg == ST_ACCEPT) && sts.out_free && !sts.busy;
    assign accept   = s_tvalid && s_tready;
    // fill stays below MAX_GROUP between items, since a full group always flushes
    assign fill_inc = fill_reg + FW'(1);
    assign pass_inc = pass_cnt_reg + grr_pkg::PLEN_W'(1);
    assign flush    = s_tlast || (grr_pkg::RLEN_W'(fill_inc) >= limit);
    assign empty    = (fill_reg == '0);

    // next state and datapath commands
    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        phase_next    = phase_reg;
        pass_cnt_next = pass_cnt_reg;
        rlen_next     = rlen_reg;
        plen_next     = plen_reg;
        cmd           = '0;
        cmd.count     = grr_pkg::CNT_W'(fill_reg);

        // configuration writes
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                grr_pkg::CFG_REVERSE_LEN: rlen_next = cfg_wr_data[grr_pkg::RLEN_W-1:0];
                grr_pkg::CFG_PASS_LEN:    plen_next = cfg_wr_data[grr_pkg::PLEN_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_ACCEPT: begin
                if (accept) begin
                    if (phase_reg) begin
                        // forwarding phase: one result per item
                        cmd.bypass_load  = 1'b1;
                        cmd.bypass_blast = 1'b1;
                        cmd.bypass_slast = s_tlast;
                        pass_cnt_next    = pass_inc;
                        if (s_tlast || pass_inc >= plen_reg) begin
                            phase_next    = 1'b0;
                            pass_cnt_next = '0;
                        end
                    end else if (!flush) begin
                        // collecting phase: store and wait
                        cmd.wr_en = 1'b1;
                        fill_next = fill_inc;
                    end else begin
                        // group complete: newest value goes straight out, rest drains
                        cmd.bypass_load  = 1'b1;
                        cmd.bypass_blast = empty;
                        cmd.bypass_slast = s_tlast && empty;
                        if (!empty) begin
                            cmd.drain_start = 1'b1;
                            cmd.drain_slast = s_tlast;
                            state_next      = ST_DRAIN;
                        end
                        fill_next     = '0;
                        pass_cnt_next = '0;
                        phase_next    = !s_tlast && (plen_reg != '0);
                    end
                end
            end
            ST_DRAIN: begin
                if (!sts.busy) begin
                    state_next = ST_ACCEPT;
                end
            end
            default: begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_ACCEPT;
            fill_reg     <= '0;
            phase_reg    <= 1'b0;
            pass_cnt_reg <= '0;
            rlen_reg     <= grr_pkg::RLEN_W'(1);
            plen_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            phase_reg    <= phase_next;
            pass_cnt_reg <= pass_cnt_next;
            rlen_reg     <= rlen_next;
            plen_reg     <= plen_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/group_reverse_reorder_top.sv @@
// top level of the group reverse reorderer
//
// Stream reorderer: collects reverse_len values and sends them newest first, then forwards
// the next pass_len values unchanged, and repeats; an item with s_tlast set flushes a partial
// group reversed and restarts the pattern. Items in the collecting and forwarding phases are
// taken one per cycle unless the output stalls. When a group completes, its newest value is
// sent at once and the older ones are read back from the group store one per cycle through
// its registered read port unless stalled, during which no item is taken. m_tuser marks the
// last result caused by one input item and m_tlast the end of the output stream.
// Configuration is to be written through cfg_wr_* only while the block is idle (unenforced).
`default_nettype none

module group_reverse_reorder_top #(
    parameter int MAX_GROUP = grr_pkg::MAX_GROUP_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [grr_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [grr_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [grr_pkg::VALUE_W-1:0]    s_tdata,  // [31:0] value
    input  wire logic                           s_tlast,  // stream_last
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [grr_pkg::VALUE_W-1:0]    m_tdata,  // [31:0] out_value
    output logic                                m_tlast,  // out_stream_last
    output logic                                m_tuser   // [0] burst_last
);

    grr_pkg::cmd_t    cmd;
    grr_pkg::status_t sts;

    grr_ctrl #(
        .MAX_GROUP(MAX_GROUP)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tlast     (s_tlast),
        .sts         (sts),
        .cmd         (cmd)
    );

    grr_dp #(
        .MAX_GROUP(MAX_GROUP)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .in_value(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

endmodule

`default_nettype wire
